FILE: hw/rtl/drt_pkg.sv
// ----------------------------------------------------------------------------
// drt_pkg: shared types and constants of the dirty region refresh tracker
// Operation codes, register indexes, reset values and inter-module structs.
// ----------------------------------------------------------------------------
package drt_pkg;

  // Coordinate width of the incoming rectangle fields
  localparam int unsigned COORD_BITS_DEF = 16;

  // Register widths
  localparam int unsigned PANEL_W = 14;
  localparam int unsigned LIMIT_W = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 14;

  // Result field widths
  localparam int unsigned POS_W = 14;
  localparam int unsigned EXT_W = 15;
  localparam int unsigned OUT_DATA_W = 64;

  // Register reset values
  localparam logic [PANEL_W-1:0] PANEL_WIDTH_RST  = PANEL_W'(800);
  localparam logic [PANEL_W-1:0] PANEL_HEIGHT_RST = PANEL_W'(480);
  localparam logic [LIMIT_W-1:0] PARTIAL_LIMIT_RST = LIMIT_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    CfgPanelWidth  = 2'd0,
    CfgPanelHeight = 2'd1,
    CfgPartialLimit = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OpMark  = 2'd0,
    OpFlush = 2'd1,
    OpFull  = 2'd2
  } op_e;

  typedef enum logic {
    RefreshPartial = 1'b0,
    RefreshFull    = 1'b1
  } refresh_e;

  // Clipped mark rectangle, inclusive corners
  typedef struct packed {
    logic             ok;
    logic [POS_W-1:0] left;
    logic [POS_W-1:0] top;
    logic [POS_W-1:0] right;
    logic [POS_W-1:0] bottom;
  } clip_t;

  // One refresh result
  typedef struct packed {
    refresh_e         kind;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [EXT_W-1:0] w;
    logic [EXT_W-1:0] h;
  } res_t;

endpackage

FILE: hw/rtl/dirty_region_refresh_tracker.sv
// ----------------------------------------------------------------------------
// dirty_region_refresh_tracker: dirty rectangle tracker for a display panel
// Collects marked regions into one bounding box and issues refresh beats.
// ----------------------------------------------------------------------------
// Each beat on the slave stream is one command, selected by tuser: mark a
// region, flush, or force a full refresh. A mark is clipped to the panel size
// and widens the pending box; it gives no output. A flush with a pending box
// gives one partial refresh of the box, or a full refresh once partial_limit
// partial refreshes have gone out since the last full one; a flush with no box
// gives nothing. A full command always gives a full refresh (all-zero box).
// Timing: a command is held in the input register, where clipping and the box
// update are done in a single pass, and its result is loaded into the output
// register when the command advances: one command per cycle is sustained while
// the refresh stream takes results. The input side stalls only while a result
// waits untaken in the output register and the input command also has a result.
// Configuration writes are always taken (cfg_ready_o is tied high) and must
// only be issued while no command is in flight.
// ----------------------------------------------------------------------------
module dirty_region_refresh_tracker #(
  parameter int unsigned COORD_BITS = drt_pkg::COORD_BITS_DEF,
  localparam int unsigned InDataW = ((4 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [drt_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [drt_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // command stream
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [InDataW-1:0]                s_axis_tdata_i,   // rect_x, rect_y, rect_w, rect_h
  input  logic [1:0]                        s_axis_tuser_i,   // op
  // refresh stream
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [drt_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,   // out_x, out_y, out_w, out_h
  output logic                              m_axis_tuser_o    // refresh_kind
);

  localparam int unsigned ResW = 2 * drt_pkg::POS_W + 2 * drt_pkg::EXT_W;

  // Configuration registers
  logic [drt_pkg::PANEL_W-1:0] panel_width_q, panel_height_q;
  logic [drt_pkg::LIMIT_W-1:0] partial_limit_q;

  // Input register
  logic                         in_vld_q;
  drt_pkg::op_e                 in_op_q;
  logic signed [COORD_BITS-1:0] in_x_q, in_y_q, in_w_q, in_h_q;

  // Output register
  logic          out_vld_q, out_vld_d;
  drt_pkg::res_t out_q;

  drt_pkg::clip_t clip;
  drt_pkg::res_t  res;
  logic           has_res;
  logic           fire;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      panel_width_q   <= drt_pkg::PANEL_WIDTH_RST;
      panel_height_q  <= drt_pkg::PANEL_HEIGHT_RST;
      partial_limit_q <= drt_pkg::PARTIAL_LIMIT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        drt_pkg::CfgPanelWidth:   panel_width_q <= cfg_data_i[drt_pkg::PANEL_W-1:0];
        drt_pkg::CfgPanelHeight:  panel_height_q <= cfg_data_i[drt_pkg::PANEL_W-1:0];
        drt_pkg::CfgPartialLimit: partial_limit_q <= cfg_data_i[drt_pkg::LIMIT_W-1:0];
        default: begin
          // no register here: drop the write
        end
      endcase
    end
  end

  // Advance the command unless its result would overwrite a waiting one
  assign fire = in_vld_q && (!has_res || !out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_op_q <= drt_pkg::op_e'(s_axis_tuser_i);
      in_x_q  <= s_axis_tdata_i[COORD_BITS-1:0];
      in_y_q  <= s_axis_tdata_i[2*COORD_BITS-1:COORD_BITS];
      in_w_q  <= s_axis_tdata_i[3*COORD_BITS-1:2*COORD_BITS];
      in_h_q  <= s_axis_tdata_i[4*COORD_BITS-1:3*COORD_BITS];
    end
  end

  drt_clip #(
    .COORD_BITS(COORD_BITS)
  ) u_clip (
    .rect_x_i      (in_x_q),
    .rect_y_i      (in_y_q),
    .rect_w_i      (in_w_q),
    .rect_h_i      (in_h_q),
    .panel_width_i (panel_width_q),
    .panel_height_i(panel_height_q),
    .clip_o        (clip)
  );

  drt_state u_state (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .op_i           (in_op_q),
    .clip_i         (clip),
    .partial_limit_i(partial_limit_q),
    .has_res_o      (has_res),
    .res_o          (res)
  );

  // Load a new result, or drop the shown one once it is taken
  always_comb begin
    out_vld_d = out_vld_q;
    if (fire && has_res) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && has_res) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_q.kind;
  assign m_axis_tdata_o  = {{(drt_pkg::OUT_DATA_W - ResW){1'b0}},
                            out_q.h, out_q.w, out_q.y, out_q.x};

endmodule

FILE: hw/rtl/drt_clip.sv
// ----------------------------------------------------------------------------
// drt_clip: rectangle clipper
// Clips a signed x/y/w/h rectangle to the panel and gives inclusive corners.
// ----------------------------------------------------------------------------
module drt_clip #(
  parameter int unsigned COORD_BITS = drt_pkg::COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0]       rect_x_i,
  input  logic signed [COORD_BITS-1:0]       rect_y_i,
  input  logic signed [COORD_BITS-1:0]       rect_w_i,
  input  logic signed [COORD_BITS-1:0]       rect_h_i,
  input  logic        [drt_pkg::PANEL_W-1:0] panel_width_i,
  input  logic        [drt_pkg::PANEL_W-1:0] panel_height_i,
  output drt_pkg::clip_t                     clip_o
);

  // Wide enough that no sum wraps
  localparam int unsigned CalcW =
      ((COORD_BITS > drt_pkg::PANEL_W) ? COORD_BITS : drt_pkg::PANEL_W) + 3;

  logic signed [CalcW-1:0] x0, y0, w0, h0;
  logic signed [CalcW-1:0] x1, y1, w1, h1;
  logic signed [CalcW-1:0] w2, h2;
  logic signed [CalcW-1:0] pw, ph;
  logic signed [CalcW-1:0] r, b;

  assign x0 = {{(CalcW-COORD_BITS){rect_x_i[COORD_BITS-1]}}, rect_x_i};
  assign y0 = {{(CalcW-COORD_BITS){rect_y_i[COORD_BITS-1]}}, rect_y_i};
  assign w0 = {{(CalcW-COORD_BITS){rect_w_i[COORD_BITS-1]}}, rect_w_i};
  assign h0 = {{(CalcW-COORD_BITS){rect_h_i[COORD_BITS-1]}}, rect_h_i};
  assign pw = {{(CalcW-drt_pkg::PANEL_W){1'b0}}, panel_width_i};
  assign ph = {{(CalcW-drt_pkg::PANEL_W){1'b0}}, panel_height_i};

  always_comb begin
    // Pull negative origins onto the panel, shrinking the extent
    x1 = (x0 < 0) ? '0 : x0;
    w1 = (x0 < 0) ? (w0 + x0) : w0;
    y1 = (y0 < 0) ? '0 : y0;
    h1 = (y0 < 0) ? (h0 + y0) : h0;
    // Cut at the far edge
    w2 = ((x1 + w1) > pw) ? (pw - x1) : w1;
    h2 = ((y1 + h1) > ph) ? (ph - y1) : h1;
    r  = x1 + w2 - CalcW'(signed'(1));
    b  = y1 + h2 - CalcW'(signed'(1));
    clip_o.ok     = (w2 > 0) && (h2 > 0);
    clip_o.left   = x1[drt_pkg::POS_W-1:0];
    clip_o.top    = y1[drt_pkg::POS_W-1:0];
    clip_o.right  = r[drt_pkg::POS_W-1:0];
    clip_o.bottom = b[drt_pkg::POS_W-1:0];
  end

endmodule

FILE: hw/rtl/drt_state.sv
// ----------------------------------------------------------------------------
// drt_state: pending box and partial refresh counter
// Holds the dirty bounding box, decides each item's refresh and updates state.
// ----------------------------------------------------------------------------
module drt_state (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  drt_pkg::op_e                  op_i,
  input  drt_pkg::clip_t                clip_i,
  input  logic [drt_pkg::LIMIT_W-1:0]   partial_limit_i,
  output logic                          has_res_o,
  output drt_pkg::res_t                 res_o
);

  logic                        box_valid_q, box_valid_d;
  logic [drt_pkg::POS_W-1:0]   left_q, left_d, top_q, top_d;
  logic [drt_pkg::POS_W-1:0]   right_q, right_d, bottom_q, bottom_d;
  logic [drt_pkg::LIMIT_W-1:0] count_q, count_d;
  logic                        limit_hit;

  assign limit_hit = (count_q >= partial_limit_i);

  always_comb begin
    box_valid_d = box_valid_q;
    left_d      = left_q;
    top_d       = top_q;
    right_d     = right_q;
    bottom_d    = bottom_q;
    count_d     = count_q;
    has_res_o   = 1'b0;
    res_o.kind  = drt_pkg::RefreshFull;
    res_o.x     = '0;
    res_o.y     = '0;
    res_o.w     = '0;
    res_o.h     = '0;
    unique case (op_i)
      drt_pkg::OpMark: begin
        if (clip_i.ok) begin
          box_valid_d = 1'b1;
          if (!box_valid_q) begin
            left_d   = clip_i.left;
            top_d    = clip_i.top;
            right_d  = clip_i.right;
            bottom_d = clip_i.bottom;
          end else begin
            if (clip_i.left < left_q)     left_d = clip_i.left;
            if (clip_i.top < top_q)       top_d = clip_i.top;
            if (clip_i.right > right_q)   right_d = clip_i.right;
            if (clip_i.bottom > bottom_q) bottom_d = clip_i.bottom;
          end
        end
      end
      drt_pkg::OpFlush: begin
        if (box_valid_q) begin
          has_res_o   = 1'b1;
          box_valid_d = 1'b0;
          if (limit_hit) begin
            count_d = '0;
          end else begin
            res_o.kind = drt_pkg::RefreshPartial;
            res_o.x    = left_q;
            res_o.y    = top_q;
            res_o.w    = {1'b0, right_q} - {1'b0, left_q} + drt_pkg::EXT_W'(1);
            res_o.h    = {1'b0, bottom_q} - {1'b0, top_q} + drt_pkg::EXT_W'(1);
            count_d    = count_q + drt_pkg::LIMIT_W'(1);
          end
        end
      end
      drt_pkg::OpFull: begin
        has_res_o   = 1'b1;
        box_valid_d = 1'b0;
        count_d     = '0;
      end
      default: begin
        // undefined op: drop
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_valid_q <= 1'b0;
      count_q     <= '0;
    end else if (fire_i) begin
      box_valid_q <= box_valid_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      left_q   <= left_d;
      top_q    <= top_d;
      right_q  <= right_d;
      bottom_q <= bottom_d;
    end
  end

`ifndef ASSERT_OFF
  a_full_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (op_i == drt_pkg::OpFull) |=> (count_q == '0) && !box_valid_q)
    else $error("full refresh did not clear box and count");

  a_box_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    box_valid_q |-> (left_q <= right_q) && (top_q <= bottom_q))
    else $error("pending box corners out of order");

  a_partial_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && (op_i == drt_pkg::OpFlush) && box_valid_q && !limit_hit
    |=> count_q == $past(count_q) + drt_pkg::LIMIT_W'(1))
    else $error("partial refresh did not advance the count");

  a_flush_empty_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == drt_pkg::OpFlush) && !box_valid_q |-> !has_res_o)
    else $error("flush without a box produced a result");
`endif

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the dirty region refresh tracker
// Drives mark, flush and full commands on the slave stream and checks each
// refresh beat on the master stream against a predictor of the pending box.
// ----------------------------------------------------------------------------
// The predictor keeps its own copy of the panel size, the refresh limit, the
// pending box and the partial refresh count. Each accepted command updates
// that copy and may queue one expected refresh beat. The checker pops the
// oldest expectation on every accepted refresh beat and compares field by
// field. Directed tests cover clipping extremes, empty regions, flush without
// a box, the undefined opcode and the refresh limit, including a limit that
// is lowered below the current count. Random phases then run under several
// register settings, with random idling on both streams, one stretch without
// idling, and one long hold-off on the refresh stream that backs up the
// command stream.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD  = 20;
  localparam int unsigned RESET_CYCLES = 6;
  localparam int unsigned DRAIN_CYCLES = 4;   // input and output registers plus margin
  localparam int unsigned HOLD_CYCLES  = 120; // long refresh stream hold-off
  localparam int unsigned IDLE_PCT     = 8;
  localparam logic [1:0]  OpUndef      = 2'd3; // opcode the block ignores

  // One expected refresh beat
  typedef struct packed {
    drt_pkg::refresh_e         kind;
    logic [drt_pkg::POS_W-1:0] x;
    logic [drt_pkg::POS_W-1:0] y;
    logic [drt_pkg::EXT_W-1:0] w;
    logic [drt_pkg::EXT_W-1:0] h;
  } refresh_beat_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;

  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [drt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [drt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic                           cmd_tvalid = 1'b0;
  logic                           cmd_tready;
  logic [63:0]                    cmd_tdata = '0;  // rect_x, rect_y, rect_w, rect_h
  logic [1:0]                     cmd_tuser = '0;  // op

  logic                           ref_tvalid;
  logic                           ref_tready = 1'b0;
  logic [drt_pkg::OUT_DATA_W-1:0] ref_tdata;       // out_x, out_y, out_w, out_h, zero pad
  logic                           ref_tuser;       // refresh_kind

  // Shared control between the test sequence and the refresh stream sink
  bit                    steady = 1'b0;   // no idling on either stream
  bit                    hold_req = 1'b0; // ask the sink for one long hold-off
  int unsigned           mismatch_count = 0;

  // Predictor state
  refresh_beat_t                refresh_q[$];
  int                           panel_w;
  int                           panel_h;
  logic [drt_pkg::LIMIT_W-1:0]  refresh_limit;
  bit                           box_valid;
  int                           box_left;
  int                           box_top;
  int                           box_right;
  int                           box_bottom;
  logic [drt_pkg::LIMIT_W-1:0]  partial_count;

  dirty_region_refresh_tracker dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (cmd_tvalid),
    .s_axis_tready_o (cmd_tready),
    .s_axis_tdata_i  (cmd_tdata),
    .s_axis_tuser_i  (cmd_tuser),
    .m_axis_tvalid_o (ref_tvalid),
    .m_axis_tready_i (ref_tready),
    .m_axis_tdata_o  (ref_tdata),
    .m_axis_tuser_o  (ref_tuser)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor: clip a mark and widen the box, or turn the box into a refresh
  // --------------------------------------------------------------------------
  function automatic void predict_refresh(logic [1:0] op, logic signed [15:0] rx,
                                          logic signed [15:0] ry, logic signed [15:0] rw,
                                          logic signed [15:0] rh);
    int x;
    int y;
    int w;
    int h;
    refresh_beat_t beat;
    x = rx;
    y = ry;
    w = rw;
    h = rh;
    case (op)
      drt_pkg::OpMark: begin
        // Clip against the top left corner first, then the panel size
        if (x < 0) begin
          w += x;
          x = 0;
        end
        if (y < 0) begin
          h += y;
          y = 0;
        end
        if (x + w > panel_w) w = panel_w - x;
        if (y + h > panel_h) h = panel_h - y;
        if (w > 0 && h > 0) begin
          if (!box_valid) begin
            box_left   = x;
            box_top    = y;
            box_right  = x + w - 1;
            box_bottom = y + h - 1;
            box_valid  = 1'b1;
          end else begin
            if (x < box_left) box_left = x;
            if (y < box_top) box_top = y;
            if (x + w - 1 > box_right) box_right = x + w - 1;
            if (y + h - 1 > box_bottom) box_bottom = y + h - 1;
          end
        end
      end
      drt_pkg::OpFlush: begin
        // No box: nothing goes out and nothing changes
        if (box_valid) begin
          if (partial_count >= refresh_limit) begin
            beat = '{kind: drt_pkg::RefreshFull, default: '0};
            partial_count = '0;
          end else begin
            beat.kind = drt_pkg::RefreshPartial;
            beat.x = drt_pkg::POS_W'(box_left);
            beat.y = drt_pkg::POS_W'(box_top);
            beat.w = drt_pkg::EXT_W'(box_right - box_left + 1);
            beat.h = drt_pkg::EXT_W'(box_bottom - box_top + 1);
            partial_count = partial_count + 1'b1;
          end
          box_valid = 1'b0;
          refresh_q.push_back(beat);
        end
      end
      drt_pkg::OpFull: begin
        beat = '{kind: drt_pkg::RefreshFull, default: '0};
        partial_count = '0;
        box_valid = 1'b0;
        refresh_q.push_back(beat);
      end
      default: ; // undefined opcode is ignored
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stream drivers
  // --------------------------------------------------------------------------

  // Offer one command beat and hold it until it is taken, then predict.
  // Valid stays high on return so back-to-back beats follow without a gap.
  task automatic send_cmd(logic [1:0] op, logic [15:0] x, logic [15:0] y,
                          logic [15:0] w, logic [15:0] h);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      cmd_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_tvalid <= 1'b1;
    cmd_tuser  <= op;
    cmd_tdata  <= {h, w, y, x};
    do @(posedge clk_i); while (!cmd_tready);
    predict_refresh(op, x, y, w, h);
  endtask

  // Write one register once the block has gone quiet
  task automatic write_reg(drt_pkg::cfg_idx_e idx, logic [drt_pkg::CFG_DATA_W-1:0] data);
    cmd_tvalid <= 1'b0;
    while (refresh_q.size() != 0) @(posedge clk_i);
    // Marks give no beat, so let any still in flight settle
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      drt_pkg::CfgPanelWidth:   panel_w = data[drt_pkg::PANEL_W-1:0];
      drt_pkg::CfgPanelHeight:  panel_h = data[drt_pkg::PANEL_W-1:0];
      drt_pkg::CfgPartialLimit: refresh_limit = data[drt_pkg::LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  // Mostly near the panel, sometimes anywhere in the signed range
  function automatic logic [15:0] pick_coord(int span);
    case ($urandom_range(9))
      0:       return 16'($urandom);
      1:       return $urandom_range(1) ? 16'h8000 : 16'h7fff;
      default: return 16'(int'($urandom_range(span + 16)) - 8);
    endcase
  endfunction

  task automatic send_random_mark();
    send_cmd(drt_pkg::OpMark, pick_coord(panel_w), pick_coord(panel_h),
             pick_coord(panel_w), pick_coord(panel_h));
  endtask

  // Refresh stream sink: random stalls, plus one long hold-off on request
  initial begin : drive_refresh_ready
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        ref_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      ref_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // --------------------------------------------------------------------------
  // Refresh beat checker
  // --------------------------------------------------------------------------
  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin : check_refresh
    refresh_beat_t want;
    if (rst_ni && ref_tvalid && ref_tready) begin
      if (refresh_q.size() == 0) begin
        $error("refresh beat with no expectation: kind %0d tdata %h", ref_tuser, ref_tdata);
        mismatch_count++;
      end else begin
        want = refresh_q.pop_front();
        check_field("refresh_kind", want.kind, ref_tuser);
        check_field("out_x", want.x, ref_tdata[13:0]);
        check_field("out_y", want.y, ref_tdata[27:14]);
        check_field("out_w", want.w, ref_tdata[42:28]);
        check_field("out_h", want.h, ref_tdata[57:43]);
        check_field("tdata_pad", 0, ref_tdata[63:58]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Clipping extremes, empty regions and each opcode at the reset settings
  task automatic test_mark_clipping();
    write_reg(drt_pkg::CfgPanelWidth, 14'd800);
    write_reg(drt_pkg::CfgPanelHeight, 14'd480);
    // Empty after clipping: far left, far right, zero and negative size
    send_cmd(drt_pkg::OpMark, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
    send_cmd(drt_pkg::OpMark, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_cmd(drt_pkg::OpMark, 16'd10, 16'd20, 16'd0, 16'd5);
    send_cmd(drt_pkg::OpMark, 16'd10, 16'd20, 16'sh8000, 16'd5);
    // Nothing pending, so the flush gives nothing
    send_cmd(drt_pkg::OpFlush, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    // Clip at the top left, widen across the bottom right, then flush
    send_cmd(drt_pkg::OpMark, -16'sd5, -16'sd7, 16'd20, 16'd30);
    send_cmd(drt_pkg::OpMark, 16'd790, 16'd470, 16'd100, 16'd100);
    send_cmd(drt_pkg::OpFlush, '0, '0, '0, '0);
    send_cmd(drt_pkg::OpMark, 16'd0, 16'd0, 16'd800, 16'd480);
    send_cmd(drt_pkg::OpFlush, '0, '0, '0, '0);
    // Undefined opcode must leave the box empty
    send_cmd(OpUndef, 16'h1234, 16'h0042, 16'h0100, 16'h0100);
    send_cmd(drt_pkg::OpFlush, '0, '0, '0, '0);
    send_cmd(drt_pkg::OpFull, '0, '0, '0, '0);
    // A full refresh drops a pending box
    send_cmd(drt_pkg::OpMark, 16'd100, 16'd100, 16'd1, 16'd1);
    send_cmd(drt_pkg::OpFull, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_cmd(drt_pkg::OpFlush, '0, '0, '0, '0);
  endtask

  // Partial refresh limit, including a limit lowered below the count
  task automatic test_refresh_limit();
    write_reg(drt_pkg::CfgPartialLimit, 14'd2);
    repeat (2) begin
      send_cmd(drt_pkg::OpMark, 16'd3, 16'd4, 16'd5, 16'd6);
      send_cmd(drt_pkg::OpFlush, '0, '0, '0, '0);
    end
    write_reg(drt_pkg::CfgPartialLimit, 14'd1);
    send_cmd(drt_pkg::OpMark, 16'd3, 16'd4, 16'd5, 16'd6);
    send_cmd(drt_pkg::OpFlush, '0, '0, '0, '0);
    // Upper data bits fall outside the limit register
    write_reg(drt_pkg::CfgPartialLimit, {6'h3f, 8'd0});
    send_cmd(drt_pkg::OpMark, 16'd7, 16'd8, 16'd9, 16'd10);
    send_cmd(drt_pkg::OpFlush, '0, '0, '0, '0);
  endtask

  // Hold the refresh stream while commands keep coming, so the input stalls
  task automatic test_output_stall();
    write_reg(drt_pkg::CfgPartialLimit, 14'd255);
    steady = 1'b1;
    hold_req = 1'b1;
    repeat (20) begin
      send_random_mark();
      send_cmd(drt_pkg::OpFlush, 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom));
    end
    steady = 1'b0;
  endtask

  // One random phase: mostly mark runs closed by a flush, some noise
  task automatic run_random_phase(logic [drt_pkg::PANEL_W-1:0] width,
                                  logic [drt_pkg::PANEL_W-1:0] height,
                                  logic [drt_pkg::LIMIT_W-1:0] limit, int unsigned n_items,
                                  bit no_idle);
    int unsigned sent;
    int unsigned roll;
    int unsigned marks;
    logic [1:0] op;
    sent = 0;
    write_reg(drt_pkg::CfgPanelWidth, width);
    write_reg(drt_pkg::CfgPanelHeight, height);
    write_reg(drt_pkg::CfgPartialLimit, {6'($urandom), limit});
    steady = no_idle;
    while (sent < n_items) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        op = 2'($urandom_range(3));
        send_cmd(op, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        if (op != OpUndef) sent++;
      end else if (roll < 14) begin
        send_cmd(drt_pkg::OpFull, 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom));
        sent++;
      end else begin
        marks = $urandom_range(4);
        repeat (marks) send_random_mark();
        send_cmd(drt_pkg::OpFlush, 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom));
        sent += marks + 1;
      end
    end
    steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    run_random_phase(14'd800, 14'd480, 8'd10, 80, 1'b0);
    run_random_phase(14'd16383, 14'd16383, 8'd255, 80, 1'b0);
    run_random_phase(14'd1, 14'd1, 8'd0, 70, 1'b0);
    run_random_phase(14'd64, 14'd40, 8'd3, 90, 1'b1);
    run_random_phase(14'd1000, 14'd700, 8'd1, 80, 1'b0);
    run_random_phase(14'd16383, 14'd1, 8'd5, 70, 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : run_tests
    // Predictor reset state matches the register reset values
    panel_w       = drt_pkg::PANEL_WIDTH_RST;
    panel_h       = drt_pkg::PANEL_HEIGHT_RST;
    refresh_limit = drt_pkg::PARTIAL_LIMIT_RST;
    box_valid     = 1'b0;
    box_left      = -1;
    box_top       = -1;
    box_right     = -1;
    box_bottom    = -1;
    partial_count = '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_mark_clipping();
    test_refresh_limit();
    test_output_stall();
    test_random_traffic();

    // Drop valid, drain every expected beat, then let the pipe settle
    cmd_tvalid <= 1'b0;
    while (refresh_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES * 4) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("PASS dirty_region_refresh_tracker");
    end else begin
      $display("FAIL dirty_region_refresh_tracker");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run
  initial begin : watchdog
    #2_000_000;
    $display("FAIL dirty_region_refresh_tracker");
    $finish;
  end

endmodule
